@@ rtl/csl_pkg.sv @@
package csl_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int SPEED_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_WIDTH  = 16;
    localparam int GUARD_SHIFT  = 8;
    // Vectoring datapath: difference (COORD_WIDTH+1), guard, growth and sign.
    localparam int VEC_WIDTH    = COORD_WIDTH + 1 + GUARD_SHIFT + 3;
    localparam int COS_WIDTH    = 32;
    localparam int HALF_TURN    = 32768;
    localparam int QUARTER_TURN = 16384;
    localparam int INV_GAIN_Q30 = 652032874;
    localparam int PROD_WIDTH   = COS_WIDTH + SPEED_WIDTH;

    typedef logic signed [VEC_WIDTH-1:0]   vec_t;
    typedef logic signed [ANGLE_WIDTH+1:0] ang_t;
    typedef logic signed [COS_WIDTH-1:0]   cos_t;
    typedef logic [SPEED_WIDTH-1:0]        speed_t;

    function automatic ang_t atan_brad(input int unsigned i);
        ang_t r;
        r = '0;
        unique case (i)
            0: r = 18'sd8192;
            1: r = 18'sd4836;
            2: r = 18'sd2555;
            3: r = 18'sd1297;
            4: r = 18'sd651;
            5: r = 18'sd326;
            6: r = 18'sd163;
            7: r = 18'sd81;
            8: r = 18'sd41;
            9: r = 18'sd20;
            10: r = 18'sd10;
            11: r = 18'sd5;
            12: r = 18'sd3;
            13: r = 18'sd1;
            14: r = 18'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/csl_if.sv @@
interface csl_in_if;
    import csl_pkg::*;
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] cur_target_x;
    logic signed [COORD_WIDTH-1:0] cur_target_y;
    logic signed [COORD_WIDTH-1:0] next_target_x;
    logic signed [COORD_WIDTH-1:0] next_target_y;
    logic next_is_free_move;
    logic [SPEED_WIDTH-1:0] speed;
    logic [SPEED_WIDTH-1:0] max_speed;
    modport source (output valid, pos_x, pos_y, cur_target_x, cur_target_y,
                    next_target_x, next_target_y, next_is_free_move, speed,
                    max_speed, input ready);
    modport sink (input valid, pos_x, pos_y, cur_target_x, cur_target_y,
                  next_target_x, next_target_y, next_is_free_move, speed,
                  max_speed, output ready);
endinterface

interface csl_out_if;
    import csl_pkg::*;
    logic valid;
    logic ready;
    logic [SPEED_WIDTH-1:0] min_speed;
    modport source (output valid, min_speed, input ready);
    modport sink (input valid, min_speed, output ready);
endinterface

@@ rtl/corner_speed_limit.sv @@
// Corner speed limit. One word in gives one word out. The block is a single
// pipeline that accepts a word every cycle unless the output is held: one stage forms the vectors
// relative to the current waypoint, one stage per CORDIC vectoring step finds
// both directions, one stage wraps the difference into a turn angle, one stage
// per CORDIC rotation step forms the cosine, one stage multiplies by the
// maximum speed and a last stage applies the speed test and drives the output.
// All stages advance together; when the output is held the whole pipeline
// holds, so no word is lost or repeated.
module corner_speed_limit
    import csl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    csl_in_if.sink     in_ch,
    csl_out_if.source  out_ch
);

    localparam int N = CORDIC_STEPS;
    localparam int NS = 2 * N + 4;

    // Pipeline advances when the output stage is empty or being taken.
    logic adv;
    logic [NS-1:0] v_reg;
    assign adv = !v_reg[NS-1] || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NS-2:0], in_ch.valid};
        end
    end

    // Stage 0: relative vectors and quadrant pre-rotation.
    vec_t   ax_reg [0:N], ay_reg [0:N], bx_reg [0:N], by_reg [0:N];
    ang_t   az_reg [0:N], bz_reg [0:N];
    logic   fl_reg [0:NS-2];
    speed_t sp_reg [0:NS-2];
    speed_t mx_reg [0:NS-2];

    function automatic void prerot(input vec_t x, input vec_t y,
                                   output vec_t xo, output vec_t yo,
                                   output ang_t zo);
        vec_t xs, ys;
        xs = x <<< GUARD_SHIFT;
        ys = y <<< GUARD_SHIFT;
        xo = xs;
        yo = ys;
        zo = '0;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                xo = ys; yo = -xs; zo = ang_t'(QUARTER_TURN);
            end
            else
            begin
                xo = -ys; yo = xs; zo = -ang_t'(QUARTER_TURN);
            end
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_t px, py, nx, ny, x0, y0, x1, y1;
            ang_t z0, z1;
            px = vec_t'(in_ch.pos_x) - vec_t'(in_ch.cur_target_x);
            py = vec_t'(in_ch.pos_y) - vec_t'(in_ch.cur_target_y);
            nx = vec_t'(in_ch.next_target_x) - vec_t'(in_ch.cur_target_x);
            ny = vec_t'(in_ch.next_target_y) - vec_t'(in_ch.cur_target_y);
            prerot(px, py, x0, y0, z0);
            prerot(nx, ny, x1, y1, z1);
            ax_reg[0] <= x0; ay_reg[0] <= y0; az_reg[0] <= z0;
            bx_reg[0] <= x1; by_reg[0] <= y1; bz_reg[0] <= z1;
            fl_reg[0] <= in_ch.next_is_free_move;
            sp_reg[0] <= in_ch.speed;
            mx_reg[0] <= in_ch.max_speed;
        end
    end

    // Side band travels along the whole pipeline.
    genvar g;
    generate
        for (g = 1; g < NS - 1; g++)
        begin : g_side
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    fl_reg[g] <= fl_reg[g-1];
                    sp_reg[g] <= sp_reg[g-1];
                    mx_reg[g] <= mx_reg[g-1];
                end
            end
        end
    endgenerate

    // Vectoring steps; y exactly zero leaves the vector alone.
    generate
        for (g = 0; g < N; g++)
        begin : g_vec
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (ay_reg[g] > 0)
                    begin
                        ax_reg[g+1] <= ax_reg[g] + (ay_reg[g] >>> g);
                        ay_reg[g+1] <= ay_reg[g] - (ax_reg[g] >>> g);
                        az_reg[g+1] <= az_reg[g] + atan_brad(g);
                    end
                    else if (ay_reg[g] < 0)
                    begin
                        ax_reg[g+1] <= ax_reg[g] - (ay_reg[g] >>> g);
                        ay_reg[g+1] <= ay_reg[g] + (ax_reg[g] >>> g);
                        az_reg[g+1] <= az_reg[g] - atan_brad(g);
                    end
                    else
                    begin
                        ax_reg[g+1] <= ax_reg[g];
                        ay_reg[g+1] <= ay_reg[g];
                        az_reg[g+1] <= az_reg[g];
                    end
                    if (by_reg[g] > 0)
                    begin
                        bx_reg[g+1] <= bx_reg[g] + (by_reg[g] >>> g);
                        by_reg[g+1] <= by_reg[g] - (bx_reg[g] >>> g);
                        bz_reg[g+1] <= bz_reg[g] + atan_brad(g);
                    end
                    else if (by_reg[g] < 0)
                    begin
                        bx_reg[g+1] <= bx_reg[g] - (by_reg[g] >>> g);
                        by_reg[g+1] <= by_reg[g] + (bx_reg[g] >>> g);
                        bz_reg[g+1] <= bz_reg[g] - atan_brad(g);
                    end
                    else
                    begin
                        bx_reg[g+1] <= bx_reg[g];
                        by_reg[g+1] <= by_reg[g];
                        bz_reg[g+1] <= bz_reg[g];
                    end
                end
            end
        end
    endgenerate

    // Turn angle: wrap the difference into (-pi, pi], take pi minus magnitude.
    // The cosine is only needed for turns of at most a quarter turn.
    cos_t cx_reg [0:N], cy_reg [0:N];
    ang_t cz_reg [0:N];
    logic ok_reg [0:N];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic [ANGLE_WIDTH-1:0] dm;
            ang_t d, mag, trn;
            dm = ANGLE_WIDTH'(az_reg[N] - bz_reg[N]);
            d = ang_t'({2'b00, dm});
            if (d >= ang_t'(HALF_TURN))
            begin
                d = d - ang_t'(2 * HALF_TURN);
            end
            if (d == -ang_t'(HALF_TURN))
            begin
                d = ang_t'(HALF_TURN);
            end
            mag = (d < 0) ? -d : d;
            trn = ang_t'(HALF_TURN) - mag;
            cx_reg[0] <= cos_t'(INV_GAIN_Q30);
            cy_reg[0] <= '0;
            cz_reg[0] <= trn;
            ok_reg[0] <= fl_reg[N] && (trn <= ang_t'(QUARTER_TURN));
        end
    end

    // Rotation steps toward the turn angle.
    generate
        for (g = 0; g < N; g++)
        begin : g_rot
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ok_reg[g+1] <= ok_reg[g];
                    if (cz_reg[g] >= 0)
                    begin
                        cx_reg[g+1] <= cx_reg[g] - (cy_reg[g] >>> g);
                        cy_reg[g+1] <= cy_reg[g] + (cx_reg[g] >>> g);
                        cz_reg[g+1] <= cz_reg[g] - atan_brad(g);
                    end
                    else
                    begin
                        cx_reg[g+1] <= cx_reg[g] + (cy_reg[g] >>> g);
                        cy_reg[g+1] <= cy_reg[g] - (cx_reg[g] >>> g);
                        cz_reg[g+1] <= cz_reg[g] + atan_brad(g);
                    end
                end
            end
        end
    endgenerate

    // Product of the cosine and the maximum speed.
    logic [PROD_WIDTH-1:0] p_reg;
    logic                  pos_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_reg <= ok_reg[N] && (cx_reg[N] > 0);
            p_reg   <= PROD_WIDTH'(cx_reg[N][COS_WIDTH-2:0]) * PROD_WIDTH'(mx_reg[2*N+1]);
        end
    end

    // Speed test and saturation.
    speed_t res_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            speed_t s;
            logic [PROD_WIDTH-1:0] thr;
            logic [PROD_WIDTH-31:0] q;
            s = sp_reg[2*N+2];
            thr = PROD_WIDTH'(s - 1'b1) << 30;
            q = p_reg[PROD_WIDTH-1:30];
            if (!pos_reg)
            begin
                res_reg <= '0;
            end
            else if (s == '0 || p_reg > thr)
            begin
                res_reg <= s;
            end
            else if (q > (PROD_WIDTH-30)'({SPEED_WIDTH{1'b1}}))
            begin
                res_reg <= '1;
            end
            else
            begin
                res_reg <= SPEED_WIDTH'(q);
            end
        end
    end

    assign out_ch.valid     = v_reg[NS-1];
    assign out_ch.min_speed = res_reg;

    // A held output word keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.min_speed))
        else $error("output word changed while stalled");

    // A stall freezes the valid chain.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("pipeline moved during stall");

    // Accepted input reaches the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> v_reg[0])
        else $error("accepted word lost at entry");

    // Ready is only withheld while a word waits at the output.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> out_ch.valid && !out_ch.ready)
        else $error("input stalled without cause");

endmodule

@@ verif/tb_corner_speed_limit.sv @@
`timescale 1ns / 1ps

// Testbench for the corner speed limit block.
// Words are pushed into the input channel with random gaps. Every accepted word
// is run through a predictor that redoes the fixed-point CORDIC math, and its
// result is queued. The output channel is stalled at random, and each output
// word is checked against the oldest queued result.
module tb_corner_speed_limit;
    import csl_pkg::*;

    localparam int LATENCY = 2 * CORDIC_STEPS + 5;
    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   idle_cycles;
    bit   quiet_phase;

    csl_in_if  in_ch ();
    csl_out_if out_ch ();

    corner_speed_limit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Expected minimum speeds, oldest first.
    speed_t min_speed_queue[$];

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Arctangent table in binary radians, one entry per CORDIC step; steps past the table add nothing.
    function automatic longint atan_step(input int i);
        longint tab[15];
        tab = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
        if (i < 15)
        begin
            return tab[i];
        end
        return 0;
    endfunction

    // Direction of a vector in binary radians; a zero vector points at angle 0.
    function automatic longint direction(input longint vx, input longint vy);
        longint x;
        longint y;
        longint z;
        longint t;
        longint xs;
        longint ys;
        x = vx <<< 8;
        y = vy <<< 8;
        z = 0;
        if (vx == 0 && vy == 0)
        begin
            return 0;
        end
        // Move the left half plane onto the right one first.
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = QUARTER_TURN;
            end
            else
            begin
                x = -y;
                y = t;
                z = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end
            else if (y < 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end
        end
        return z;
    endfunction

    // Cosine of a turn angle, Q30.
    function automatic longint cosine_q30(input longint turn);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = INV_GAIN_Q30;
        y = 0;
        z = turn;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end
        end
        return x;
    endfunction

    function automatic speed_t corner_speed(
        input logic signed [COORD_WIDTH-1:0] px, input logic signed [COORD_WIDTH-1:0] py,
        input logic signed [COORD_WIDTH-1:0] cx, input logic signed [COORD_WIDTH-1:0] cy,
        input logic signed [COORD_WIDTH-1:0] nx, input logic signed [COORD_WIDTH-1:0] ny,
        input logic free_move, input speed_t spd, input speed_t vmax);
        longint a_pos;
        longint a_next;
        longint diff;
        longint turn;
        longint c;
        longint unsigned prod;
        longint unsigned lim;
        if (!free_move)
        begin
            return '0;
        end
        a_pos  = direction(longint'(px) - longint'(cx), longint'(py) - longint'(cy));
        a_next = direction(longint'(nx) - longint'(cx), longint'(ny) - longint'(cy));
        // Wrap into (-pi, pi]; minus pi counts as plus pi.
        diff = (a_pos - a_next) & 64'hFFFF;
        if (diff >= HALF_TURN)
        begin
            diff = diff - 2 * HALF_TURN;
        end
        if (diff == -HALF_TURN)
        begin
            diff = HALF_TURN;
        end
        turn = HALF_TURN - ((diff < 0) ? -diff : diff);
        if (turn > QUARTER_TURN)
        begin
            return '0;
        end
        c = cosine_q30(turn);
        if (c <= 0)
        begin
            return '0;
        end
        prod = longint'(c) * longint'(vmax);
        lim  = (longint'(spd) - 1) <<< 30;
        // The speed test uses the product before truncation.
        if (spd == 0 || prod > lim)
        begin
            return spd;
        end
        if ((prod >> 30) > 64'hFFFF)
        begin
            return '1;
        end
        return speed_t'(prod >> 30);
    endfunction

    // Random gap decision: idle with a chance of 38 in 100 outside quiet phases.
    function automatic bit idle_now();
        return !quiet_phase && ($urandom_range(99) < 38);
    endfunction

    task automatic send_word(
        input logic signed [COORD_WIDTH-1:0] px, input logic signed [COORD_WIDTH-1:0] py,
        input logic signed [COORD_WIDTH-1:0] cx, input logic signed [COORD_WIDTH-1:0] cy,
        input logic signed [COORD_WIDTH-1:0] nx, input logic signed [COORD_WIDTH-1:0] ny,
        input logic free_move, input speed_t spd, input speed_t vmax);
        while (idle_now())
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.pos_x             <= px;
        in_ch.pos_y             <= py;
        in_ch.cur_target_x      <= cx;
        in_ch.cur_target_y      <= cy;
        in_ch.next_target_x     <= nx;
        in_ch.next_target_y     <= ny;
        in_ch.next_is_free_move <= free_move;
        in_ch.speed             <= spd;
        in_ch.max_speed         <= vmax;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        min_speed_queue.push_back(corner_speed(px, py, cx, cy, nx, ny, free_move, spd, vmax));
        // Valid stays high here; the next call lowers or reloads it once.
    endtask

    task automatic release_input();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // A well-formed corner: waypoint c, robot and next waypoint around it.
    task automatic send_corner(input int span, input speed_t spd, input speed_t vmax);
        int cx;
        int cy;
        cx = $urandom_range(16777215) - 8388608;
        cy = $urandom_range(16777215) - 8388608;
        cx = (cx > 8388607 - span) ? 8388607 - span : cx;
        cx = (cx < -8388608 + span) ? -8388608 + span : cx;
        cy = (cy > 8388607 - span) ? 8388607 - span : cy;
        cy = (cy < -8388608 + span) ? -8388608 + span : cy;
        send_word(cx + $urandom_range(2 * span) - span, cy + $urandom_range(2 * span) - span,
                  cx, cy,
                  cx + $urandom_range(2 * span) - span, cy + $urandom_range(2 * span) - span,
                  1'b1, spd, vmax);
    endtask

    task automatic test_flag_clear();
        send_word(100, 0, 0, 0, -100, 0, 1'b0, 500, 1000);
        send_word('1, '1, '1, '1, '1, '1, 1'b0, '1, '1);
    endtask

    // Straight line, right angles, reversals, zero vectors and axis cases.
    task automatic test_geometry();
        send_word(-1000, 0, 0, 0, 1000, 0, 1'b1, 10, 40000);
        send_word(-1000, 0, 0, 0, 0, 1000, 1'b1, 10, 40000);
        send_word(-1000, 0, 0, 0, -500, 0, 1'b1, 10, 40000);
        send_word(0, -7, 0, 0, 0, 9, 1'b1, 0, 65535);
        send_word(5, 5, 5, 5, 1, 2, 1'b1, 100, 200);
        send_word(5, 5, 5, 5, 5, 5, 1'b1, 100, 200);
        send_word(-1000, 0, 0, 0, 707, 707, 1'b1, 1, 65535);
        send_word(-1000, -1, 0, 0, 1000, 1, 1'b1, 65535, 65535);
        send_word(0, 1000, 0, 0, 0, -1000, 1'b1, 65535, 1);
    endtask

    // Coordinate extremes, including the widest differences.
    task automatic test_extremes();
        send_word(24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF,
                  24'sh7FFFFF, 24'sh800000, 1'b1, 65535, 65535);
        send_word(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
                  24'sh800000, 24'sh7FFFFF, 1'b1, 1, 65535);
        send_word(24'sh800000, 0, 24'sh7FFFFF, 0, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 0, 0);
        send_word(24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 24'sh800000, 24'sh800000, 1'b1, 300, 65535);
    endtask

    // Speed test around speed - 1 and small values.
    task automatic test_speed_edges();
        send_word(-100, 0, 0, 0, 100, 0, 1'b1, 1, 0);
        send_word(-100, 0, 0, 0, 100, 0, 1'b1, 65535, 65534);
        send_word(-100, 0, 0, 0, 100, 0, 1'b1, 2, 1);
        send_word(-100, 0, 0, 0, 100, 10, 1'b1, 30000, 30000);
    endtask

    task automatic test_random(input int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            quiet_phase = (n >= count / 3) && (n < count / 3 + 150);
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                send_corner(($urandom_range(3) == 0) ? 8000000 : 1 << $urandom_range(12),
                            $urandom_range(65535), $urandom_range(65535));
            end
            else if (pick < 65)
            begin
                // Corners with small speeds and spans up to 1 << 20.
                send_corner(1 << $urandom_range(20), $urandom_range(200),
                            $urandom_range(65535));
            end
            else if (pick < 85)
            begin
                send_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom_range(1), $urandom, $urandom);
            end
            else
            begin
                // Axis-aligned and degenerate neighbors of the waypoint.
                send_word($urandom_range(1) ? $urandom_range(50) : 0,
                          $urandom_range(1) ? -$urandom_range(50) : 0, 0, 0,
                          $urandom_range(1) ? -$urandom_range(50) : 0,
                          $urandom_range(1) ? $urandom_range(50) : 0,
                          1'b1, $urandom, $urandom);
            end
        end
        quiet_phase = 1'b0;
    endtask

    // Output side: random stalls and the field check.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (min_speed_queue.size() == 0)
                begin
                    $error("min_speed: no word expected, got %0d", out_ch.min_speed);
                    fail_count++;
                end
                else
                begin
                    if (out_ch.min_speed !== min_speed_queue[0])
                    begin
                        $error("min_speed: expected %0d, got %0d",
                               min_speed_queue[0], out_ch.min_speed);
                        fail_count++;
                    end
                    void'(min_speed_queue.pop_front());
                end
            end
            out_ch.ready <= !idle_now();
        end
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        fail_count  = 0;
        idle_cycles = 0;
        quiet_phase = 1'b0;
        rst_n       = 1'b0;
        in_ch.valid             = 1'b0;
        in_ch.pos_x             = '0;
        in_ch.pos_y             = '0;
        in_ch.cur_target_x      = '0;
        in_ch.cur_target_y      = '0;
        in_ch.next_target_x     = '0;
        in_ch.next_target_y     = '0;
        in_ch.next_is_free_move = 1'b0;
        in_ch.speed             = '0;
        in_ch.max_speed         = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_flag_clear();
        test_geometry();
        test_extremes();
        test_speed_edges();
        test_random(1500);
        release_input();

        while (min_speed_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 10) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/csl_pkg.sv
rtl/csl_if.sv
rtl/corner_speed_limit.sv
verif/tb_corner_speed_limit.sv
